### hw/rtl/ibs_pkg.sv
// ----------------------------------------------------------------------------
// ibs_pkg: shared types for the integer block sorter
// Command word passed from the intake stage to the sort engine, plus queue
// sizing.
// ----------------------------------------------------------------------------
package ibs_pkg;

  localparam int unsigned VALUE_W     = 32;
  localparam int unsigned QUEUE_DEPTH = 2;

  // One classified input item
  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic                      store;  // element goes into the buffer
    logic                      close;  // item ends the set
    logic                      ovf;    // set has dropped at least one element
  } ibs_cmd_t;

endpackage

### hw/rtl/ibs_queue.sv
// ----------------------------------------------------------------------------
// ibs_queue: command queue
// Small register FIFO between the intake stage and the sort engine.
// ----------------------------------------------------------------------------
module ibs_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  ibs_pkg::ibs_cmd_t push_data_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              valid_o,
  output ibs_pkg::ibs_cmd_t pop_data_o
);
  import ibs_pkg::*;

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  ibs_cmd_t             entry_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]     wp_q, rp_q;
  logic [CNT_W-1:0]     cnt_q;

  assign full_o     = (cnt_q == CNT_W'(QUEUE_DEPTH));
  assign valid_o    = (cnt_q != '0);
  assign pop_data_o = entry_q[rp_q];

  // storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wp_q] <= push_data_i;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wp_q <= (wp_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wp_q + 1'b1;
      end
      if (pop_i) begin
        rp_q <= (rp_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rp_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

### hw/rtl/ibs_front.sv
// ----------------------------------------------------------------------------
// ibs_front: intake stage
// Accepts input items, tracks buffer fill per set and tags each item as
// stored or dropped before queueing it.
// ----------------------------------------------------------------------------
module ibs_front #(
  parameter int unsigned MAX_ITEMS = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic signed [31:0]          value_i,
  input  logic                        last_item_i,
  input  logic                        q_full_i,
  output logic                        push_o,
  output ibs_pkg::ibs_cmd_t           cmd_o
);
  import ibs_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_ITEMS + 1);

  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             drop_q, drop_d;
  logic             room;

  assign in_stall_o = q_full_i;
  assign push_o     = in_valid_i && !q_full_i;
  assign room       = (cnt_q < CNT_W'(MAX_ITEMS));

  // classify the item
  always_comb begin
    cmd_o.value = value_i;
    cmd_o.store = room;
    cmd_o.close = last_item_i;
    cmd_o.ovf   = drop_q || !room;
  end

  // per-set fill tracking
  always_comb begin
    cnt_d  = cnt_q;
    drop_d = drop_q;
    if (push_o) begin
      if (last_item_i) begin
        cnt_d  = '0;
        drop_d = 1'b0;
      end else if (room) begin
        cnt_d = cnt_q + 1'b1;
      end else begin
        drop_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      drop_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      drop_q <= drop_d;
    end
  end

endmodule

### hw/rtl/ibs_back.sv
// ----------------------------------------------------------------------------
// ibs_back: sort engine
// Buffers elements in a memory, runs an exchange sort pass by pass with one
// comparator and emits each pass minimum through an output register.
// ----------------------------------------------------------------------------
module ibs_back #(
  parameter int unsigned MAX_ITEMS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_valid_i,
  input  ibs_pkg::ibs_cmd_t   cmd_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic signed [31:0]  sorted_value_o,
  output logic                final_result_o,
  output logic                overflow_o
);
  import ibs_pkg::*;

  localparam int unsigned IDX_W = $clog2(MAX_ITEMS);
  localparam int unsigned CNT_W = $clog2(MAX_ITEMS + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_HEAD  = 3'd1;
  localparam logic [2:0] S_FIRST = 3'd2;
  localparam logic [2:0] S_SCAN  = 3'd3;
  localparam logic [2:0] S_EMIT  = 3'd4;

  logic [2:0]                state_q, state_d;
  logic [CNT_W-1:0]          wptr_q, wptr_d;
  logic [CNT_W-1:0]          n_q, n_d;
  logic [CNT_W-1:0]          i_q, i_d;
  logic [CNT_W-1:0]          k_q, k_d;
  logic [CNT_W-1:0]          k_prev;
  logic                      ovf_q, ovf_d;
  logic signed [VALUE_W-1:0] cur_q, cur_d;

  // element buffer, one write and one registered read port
  logic signed [VALUE_W-1:0] mem [MAX_ITEMS];
  logic signed [VALUE_W-1:0] rdata_q;
  logic                      we;
  logic [IDX_W-1:0]          waddr, raddr;
  logic signed [VALUE_W-1:0] wdata;

  // output register
  logic                      out_valid_q, out_valid_d;
  logic signed [VALUE_W-1:0] out_value_q, out_value_d;
  logic                      out_final_q, out_final_d;
  logic                      out_ovf_q, out_ovf_d;
  logic                      out_free;

  assign out_free       = !out_valid_q || !out_stall_i;
  assign out_valid_o    = out_valid_q;
  assign sorted_value_o = out_value_q;
  assign final_result_o = out_final_q;
  assign overflow_o     = out_ovf_q;
  assign pop_o          = (state_q == S_IDLE) && q_valid_i;
  assign k_prev         = k_q - 1'b1;

  // sequencer
  always_comb begin
    state_d     = state_q;
    wptr_d      = wptr_q;
    n_d         = n_q;
    i_d         = i_q;
    k_d         = k_q;
    ovf_d       = ovf_q;
    cur_d       = cur_q;
    we          = 1'b0;
    waddr       = wptr_q[IDX_W-1:0];
    wdata       = cmd_i.value;
    raddr       = '0;
    out_valid_d = out_valid_q && out_stall_i;
    out_value_d = out_value_q;
    out_final_d = out_final_q;
    out_ovf_d   = out_ovf_q;

    unique case (state_q)
      S_IDLE: begin
        if (q_valid_i) begin
          if (cmd_i.store) begin
            we     = 1'b1;
            wptr_d = wptr_q + 1'b1;
          end
          if (cmd_i.close) begin
            n_d     = wptr_q + CNT_W'(cmd_i.store);
            wptr_d  = '0;
            ovf_d   = cmd_i.ovf;
            i_d     = '0;
            state_d = S_HEAD;
          end
        end
      end
      S_HEAD: begin
        raddr   = i_q[IDX_W-1:0];
        k_d     = i_q + 1'b1;
        state_d = S_FIRST;
      end
      S_FIRST: begin
        cur_d = rdata_q;
        if (k_q < n_q) begin
          raddr   = k_q[IDX_W-1:0];
          k_d     = k_q + 1'b1;
          state_d = S_SCAN;
        end else begin
          state_d = S_EMIT;
        end
      end
      S_SCAN: begin
        // rdata_q holds entry k-1; swap it with the running minimum if smaller
        if (rdata_q < cur_q) begin
          we    = 1'b1;
          waddr = k_prev[IDX_W-1:0];
          wdata = cur_q;
          cur_d = rdata_q;
        end
        if (k_q < n_q) begin
          raddr = k_q[IDX_W-1:0];
          k_d   = k_q + 1'b1;
        end else begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_value_d = cur_q;
          out_final_d = (i_q + 1'b1 == n_q);
          out_ovf_d   = ovf_q;
          if (i_q + 1'b1 == n_q) begin
            state_d = S_IDLE;
          end else begin
            i_d     = i_q + 1'b1;
            state_d = S_HEAD;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // memory
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_q <= mem[raddr];
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    n_q         <= n_d;
    i_q         <= i_d;
    k_q         <= k_d;
    ovf_q       <= ovf_d;
    cur_q       <= cur_d;
    out_value_q <= out_value_d;
    out_final_q <= out_final_d;
    out_ovf_q   <= out_ovf_d;
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      wptr_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      wptr_q      <= wptr_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

### hw/rtl/integer_block_sorter.sv
// ----------------------------------------------------------------------------
// integer_block_sorter: block sorter for signed 32-bit values
//
//   channel  direction  handshake             payload
//   input    in         in_valid_i/in_stall_o value_i, last_item_i
//   output   out        out_valid_o/out_stall_i sorted_value_o,
//                                             final_result_o, overflow_o
//
// Items load at one per cycle through a two-entry command queue while the
// sort engine is idle. A set of n elements is sorted by one comparator
// working on the buffer memory's single read port: pass i scans n-i-1
// entries. Input is stalled only while the queue is full; the output
// register holds a result while out_stall_i is high. Reset clears control
// state only.
// ----------------------------------------------------------------------------
module integer_block_sorter #(
  parameter int unsigned MAX_ITEMS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [31:0] value_i,
  input  logic               last_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] sorted_value_o,
  output logic               final_result_o,
  output logic               overflow_o
);
  import ibs_pkg::*;

  logic     q_push, q_full, q_pop, q_valid;
  ibs_cmd_t push_cmd, pop_cmd;

  ibs_front #(.MAX_ITEMS(MAX_ITEMS)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .value_i     (value_i),
    .last_item_i (last_item_i),
    .q_full_i    (q_full),
    .push_o      (q_push),
    .cmd_o       (push_cmd)
  );

  ibs_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (push_cmd),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .pop_data_o  (pop_cmd)
  );

  ibs_back #(.MAX_ITEMS(MAX_ITEMS)) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_valid_i      (q_valid),
    .cmd_i          (pop_cmd),
    .pop_o          (q_pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .sorted_value_o (sorted_value_o),
    .final_result_o (final_result_o),
    .overflow_o     (overflow_o)
  );

  // queue never written while full, never read while empty
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> !q_full)
    else $error("command pushed into full queue");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_valid)
    else $error("command popped from empty queue");

  // a full queue with no pop stays full and keeps the input stalled
  a_full_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_full && !q_pop |=> q_full && in_stall_o)
    else $error("queue lost an entry without a pop");

endmodule

### test/ibs_sort_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ibs_sort_checker: result checker for the integer block sorter
// Watches both channels of the sorter. Elements that fit go into a local
// copy of the element buffer; a marked item sorts that copy and queues the
// ordered results. Each output transfer is compared field by field against
// the oldest queued result. Mismatch and pending counts go back to the top.
// ----------------------------------------------------------------------------
module ibs_sort_checker #(
  parameter int unsigned MAX_ITEMS = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  input  logic                               in_stall_i,
  input  logic signed [ibs_pkg::VALUE_W-1:0] value_i,
  input  logic                               last_item_i,
  input  logic                               out_valid_i,
  input  logic                               out_stall_i,
  input  logic signed [ibs_pkg::VALUE_W-1:0] sorted_value_i,
  input  logic                               final_result_i,
  input  logic                               overflow_i,
  output int                                 fail_count_o,
  output int                                 pending_o
);

  // One predicted output transfer
  typedef struct packed {
    logic signed [ibs_pkg::VALUE_W-1:0] value;
    logic                               final_flag;
    logic                               ovf;
  } sorted_entry_t;

  logic signed [ibs_pkg::VALUE_W-1:0] held_values [MAX_ITEMS];
  int                                 held_count;
  logic                               set_dropped;
  sorted_entry_t                      ordered_q [$];
  int                                 mismatches;

  assign fail_count_o = mismatches;

  // Ascending signed order of the held elements
  function automatic void order_held();
    logic signed [ibs_pkg::VALUE_W-1:0] key;
    int                                 j;
    for (int i = 1; i < held_count; i++) begin
      key = held_values[i];
      j   = i - 1;
      while (j >= 0 && held_values[j] > key) begin
        held_values[j+1] = held_values[j];
        j--;
      end
      held_values[j+1] = key;
    end
  endfunction

  // Store one element; a marked item closes the set and queues its results
  function automatic void take_element(logic signed [ibs_pkg::VALUE_W-1:0] v, logic closes);
    sorted_entry_t entry;
    if (held_count < MAX_ITEMS) begin
      held_values[held_count] = v;
      held_count++;
    end else begin
      set_dropped = 1'b1;
    end
    if (closes) begin
      order_held();
      for (int k = 0; k < held_count; k++) begin
        entry.value      = held_values[k];
        entry.final_flag = (k + 1 == held_count);
        entry.ovf        = set_dropped;
        ordered_q.push_back(entry);
      end
      held_count  = 0;
      set_dropped = 1'b0;
    end
  endfunction

  // Compare one output transfer with the oldest prediction
  function automatic void check_result();
    sorted_entry_t want;
    if (ordered_q.size() == 0) begin
      $error("unexpected result: sorted_value=%0d final_result=%0b overflow=%0b",
             sorted_value_i, final_result_i, overflow_i);
      mismatches++;
    end else begin
      want = ordered_q.pop_front();
      if (sorted_value_i !== want.value) begin
        $error("sorted_value: expected %0d, actual %0d", want.value, sorted_value_i);
        mismatches++;
      end
      if (final_result_i !== want.final_flag) begin
        $error("final_result: expected %0b, actual %0b", want.final_flag, final_result_i);
        mismatches++;
      end
      if (overflow_i !== want.ovf) begin
        $error("overflow: expected %0b, actual %0b", want.ovf, overflow_i);
        mismatches++;
      end
    end
  endfunction

  // Transfer monitor
  always @(posedge clk_i or negedge rst_ni) begin : monitor
    if (!rst_ni) begin
      held_count  = 0;
      set_dropped = 1'b0;
      mismatches  = 0;
      ordered_q.delete();
      pending_o  <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) check_result();
      if (in_valid_i && !in_stall_i) take_element(value_i, last_item_i);
      pending_o <= ordered_q.size();
    end
  end

endmodule

### test/tb_integer_block_sorter.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_integer_block_sorter: testbench for the integer block sorter
// Sends directed sets (extreme values, duplicates, a single element, a full
// buffer with the marker dropped) and then random sets of mixed sizes,
// overflowing ones included, with random gaps on the input and random stall
// on the output. A checker beside the block predicts and compares results.
// ----------------------------------------------------------------------------
module tb_integer_block_sorter;

  localparam int unsigned MAX_ITEMS   = 16;
  localparam int unsigned ITEM_TARGET = 460;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned TAIL_CYCLES = 250;

  localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] VAL_MAX = 32'sh7FFF_FFFF;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  logic signed [31:0] value_i;
  logic               last_item_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic signed [31:0] sorted_value_o;
  logic               final_result_o;
  logic               overflow_o;
  int                 fail_count;
  int                 pending;
  int unsigned        cycle_count = 0;
  int unsigned        items_sent;

  integer_block_sorter #(
    .MAX_ITEMS (MAX_ITEMS)
  ) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .value_i        (value_i),
    .last_item_i    (last_item_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .sorted_value_o (sorted_value_o),
    .final_result_o (final_result_o),
    .overflow_o     (overflow_o)
  );

  ibs_sort_checker #(
    .MAX_ITEMS (MAX_ITEMS)
  ) checker_i (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_i     (in_stall_o),
    .value_i        (value_i),
    .last_item_i    (last_item_i),
    .out_valid_i    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .sorted_value_i (sorted_value_o),
    .final_result_i (final_result_o),
    .overflow_i     (overflow_o),
    .fail_count_o   (fail_count),
    .pending_o      (pending)
  );

  // 4 ns clock
  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Idle length: mostly short, now and then long
  function automatic int idle_len(int zero_pct);
    int r;
    r = $urandom_range(0, 99);
    if (r < zero_pct) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Element value by flavor: full range, narrow (duplicates), extremes
  function automatic logic signed [31:0] pick_value(int flavor);
    case (flavor)
      0: return $urandom;
      1: return $signed($urandom_range(0, 8)) - 4;
      2: begin
        case ($urandom_range(0, 5))
          0: return VAL_MIN;
          1: return VAL_MAX;
          2: return VAL_MIN + 1;
          3: return VAL_MAX - 1;
          4: return -1;
          default: return 0;
        endcase
      end
      default: return $urandom_range(0, 1) ? $urandom : pick_value(1);
    endcase
  endfunction

  // One input transfer after an optional gap; valid stays high if no gap
  task automatic send_item(input logic signed [31:0] v, input logic lst, input int gap);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    value_i     <= v;
    last_item_i <= lst;
    do @(posedge clk_i); while (in_stall_o);
    items_sent++;
  endtask

  // Hold the input until every predicted result has been seen
  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // Random output stall, with quiet stretches
  initial begin : stall_gen
    int hold;
    int quiet;
    int r;
    hold        = 0;
    quiet       = 0;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (quiet > 0) begin
        quiet--;
        out_stall_i <= 1'b0;
      end else if (hold > 0) begin
        hold--;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 2) begin
          quiet       = $urandom_range(100, 300);
          out_stall_i <= 1'b0;
        end else if (r < 30) begin
          hold        = idle_len(0) - 1;
          out_stall_i <= 1'b1;
        end else begin
          out_stall_i <= 1'b0;
        end
      end
    end
  end

  // Stimulus and verdict
  initial begin : stimulus
    int set_len;
    int flavor;
    int r;
    int zero_pct;
    items_sent  = 0;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    value_i     = '0;
    last_item_i = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // single element, most negative
    send_item(VAL_MIN, 1'b1, 0);
    drain_results();
    // two elements at both ends, reverse order
    send_item(VAL_MAX, 1'b0, 0);
    send_item(VAL_MIN, 1'b1, 0);
    // duplicates around zero
    send_item(32'sd1, 1'b0, 0);
    send_item(-32'sd1, 1'b0, 1);
    send_item(32'sd0, 1'b0, 0);
    send_item(-32'sd1, 1'b1, 0);
    // full buffer; the marked seventeenth element is dropped but closes the set
    for (int i = 0; i < MAX_ITEMS; i++) begin
      send_item((i % 2) ? VAL_MAX - i : VAL_MIN + i, 1'b0, 0);
    end
    send_item(32'sd12345, 1'b1, 0);
    drain_results();

    // random sets
    while (items_sent < ITEM_TARGET) begin
      r = $urandom_range(0, 99);
      if (r < 65) set_len = $urandom_range(1, 8);
      else if (r < 88) set_len = $urandom_range(9, MAX_ITEMS);
      else set_len = $urandom_range(MAX_ITEMS + 1, MAX_ITEMS + 4);
      flavor   = $urandom_range(0, 3);
      zero_pct = $urandom_range(0, 3) == 0 ? 100 : 70;
      for (int i = 0; i < set_len; i++) begin
        send_item(pick_value(flavor), i == set_len - 1, idle_len(zero_pct));
      end
      if ($urandom_range(0, 9) == 0) drain_results();
    end

    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
